// File: src/nwt_pkg.sv
// Package with widths, token codes, state encodings and control structs for word-token spelling.
`default_nettype none
package nwt_pkg;

   localparam int VAL_W  = 64;
   localparam int WORD_W = 6;
   localparam int MAG_W  = 50;
   localparam int DIG_N  = 18;
   localparam int BCD_W  = 4 * DIG_N;
   localparam int GRP_N  = 6;
   localparam int GRP_W  = $clog2(GRP_N);
   localparam int ITER_W = $clog2(MAG_W);

   localparam logic [VAL_W-1:0] LIMIT = 64'd1000000000000000;

   localparam logic [WORD_W-1:0] TOK_ZERO     = 6'd0;
   localparam logic [WORD_W-1:0] TOK_TEN      = 6'd10;
   localparam logic [WORD_W-1:0] TOK_TENS_OFS = 6'd18;
   localparam logic [WORD_W-1:0] TOK_HUNDRED  = 6'd28;
   localparam logic [WORD_W-1:0] TOK_MINUS    = 6'd34;
   localparam logic [WORD_W-1:0] TOK_RANGE    = 6'd35;

   localparam logic [3:0] DIG_ZERO = 4'd0;
   localparam logic [3:0] DIG_ONE  = 4'd1;
   localparam logic [3:0] DIG_TWO  = 4'd2;
   localparam logic [3:0] DIG_FIVE = 4'd5;
   localparam logic [3:0] DIG_ADJ  = 4'd3;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_SINGLE,
      ST_CONV,
      ST_SIGN,
      ST_HDIG,
      ST_HWORD,
      ST_TENS,
      ST_UNITS,
      ST_SCALE,
      ST_SHIFT
   } state_type;

   typedef enum logic [2:0] {
      TK_SINGLE,
      TK_MINUS,
      TK_HDIG,
      TK_HWORD,
      TK_TENS,
      TK_UNITS,
      TK_SCALE
   } kind_type;

   typedef struct packed {
      logic     load;
      logic     check;
      logic     conv;
      logic     shift;
      logic     emit;
      kind_type kind;
   } cmd_type;

   typedef struct packed {
      logic       over;
      logic       zero;
      logic       neg;
      logic [3:0] dig_h;
      logic [3:0] dig_t;
      logic [3:0] dig_u;
      logic       grp_last;
      logic       out_free;
   } status_type;

endpackage
`default_nettype wire

// File: src/nwt_req_if.sv
// Interface for the input channel that carries one signed value per transaction.
`default_nettype none
interface nwt_req_if
   import nwt_pkg::*;
   ();
   logic                    valid;
   logic                    ready;
   logic signed [VAL_W-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface
`default_nettype wire

// File: src/nwt_rsp_if.sv
// Interface for the result channel that carries one word token per transaction.
`default_nettype none
interface nwt_rsp_if
   import nwt_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [WORD_W-1:0] word;
   logic              last;

   modport source (output valid, output word, output last, input ready);
   modport sink   (input valid, input word, input last, output ready);
endinterface
`default_nettype wire

// File: src/nwt_ctrl.sv
// Controller state machine that sequences conversion and token emission.
`default_nettype none
module nwt_ctrl
   import nwt_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire status_type status,
   output cmd_type         cmd
);

   state_type          state_ff, state_in;
   logic [ITER_W-1:0]  cnt_ff, cnt_in;
   logic               grp_nz;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      grp_nz    = (status.dig_h != DIG_ZERO) || (status.dig_t != DIG_ZERO) ||
                  (status.dig_u != DIG_ZERO);
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      req_ready = 1'b0;
      cmd       = '{load: 1'b0, check: 1'b0, conv: 1'b0, shift: 1'b0, emit: 1'b0,
                    kind: TK_SINGLE};
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            cmd.check = 1'b1;
            cnt_in    = '0;
            if (status.over || status.zero) begin
               state_in = ST_SINGLE;
            end else begin
               state_in = ST_CONV;
            end
         end
         ST_SINGLE: begin
            cmd.kind = TK_SINGLE;
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_CONV: begin
            cmd.conv = 1'b1;
            if (cnt_ff == ITER_W'(MAG_W - 1)) begin
               cnt_in   = '0;
               state_in = status.neg ? ST_SIGN : ST_HDIG;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_SIGN: begin
            cmd.kind = TK_MINUS;
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_HDIG;
            end
         end
         ST_HDIG: begin
            cmd.kind = TK_HDIG;
            if (status.dig_h == DIG_ZERO) begin
               state_in = ST_TENS;
            end else if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_HWORD;
            end
         end
         ST_HWORD: begin
            cmd.kind = TK_HWORD;
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_TENS;
            end
         end
         ST_TENS: begin
            cmd.kind = TK_TENS;
            if (status.dig_t == DIG_ZERO) begin
               state_in = ST_UNITS;
            end else if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = (status.dig_t == DIG_ONE) ? ST_SCALE : ST_UNITS;
            end
         end
         ST_UNITS: begin
            cmd.kind = TK_UNITS;
            if (status.dig_u == DIG_ZERO) begin
               state_in = ST_SCALE;
            end else if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_SCALE;
            end
         end
         ST_SCALE: begin
            cmd.kind = TK_SCALE;
            if (!grp_nz || status.grp_last) begin
               state_in = ST_SHIFT;
            end else if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_SHIFT;
            end
         end
         ST_SHIFT: begin
            cmd.shift = 1'b1;
            state_in  = status.grp_last ? ST_IDLE : ST_HDIG;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

`ifndef SYNTHESIS
   a_emit_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> status.out_free)
      else $error("Token emitted while the output register was still occupied.");

   a_conv_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CONV) |-> (cnt_ff < ITER_W'(MAG_W)))
      else $error("Conversion counter ran past the magnitude width.");

   a_accept_check: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_CHECK))
      else $error("Accepted transaction was not followed by the range check.");
`endif

endmodule
`default_nettype wire

// File: src/nwt_dp.sv
// Datapath with range check, binary to BCD conversion, token selection and output register.
`default_nettype none
module nwt_dp
   import nwt_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [VAL_W-1:0]  req_value,
   input  wire cmd_type           cmd,
   output status_type             status,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic [WORD_W-1:0]      rsp_word,
   output logic                   rsp_last
);

   logic [VAL_W-1:0]  val_ff, val_in;
   logic              neg_ff, neg_in;
   logic              over_ff, over_in;
   logic [MAG_W-1:0]  bin_ff, bin_in;
   logic [BCD_W-1:0]  bcd_ff, bcd_in;
   logic [GRP_W-1:0]  grp_ff, grp_in;
   logic [WORD_W-1:0] word_ff, word_in;
   logic              last_ff, last_in;
   logic              valid_ff, valid_in;

   logic [VAL_W-1:0]  mag;
   logic [BCD_W-1:0]  adj;
   logic [3:0]        dig;
   logic [3:0]        dig_h, dig_t, dig_u;
   logic              grp_last;
   logic              low_zero;
   logic              out_free;
   logic [WORD_W-1:0] tok;
   logic              tok_last;

   assign dig_h    = bcd_ff[BCD_W-1 -: 4];
   assign dig_t    = bcd_ff[BCD_W-5 -: 4];
   assign dig_u    = bcd_ff[BCD_W-9 -: 4];
   assign grp_last = (grp_ff == '0);
   assign low_zero = (bcd_ff[BCD_W-13:0] == '0);
   assign out_free = !valid_ff || rsp_ready;
   assign mag      = val_ff[VAL_W-1] ? (~val_ff + 1'b1) : val_ff;

   always_comb begin
      status.over     = (mag > LIMIT);
      status.zero     = (val_ff == '0);
      status.neg      = neg_ff;
      status.dig_h    = dig_h;
      status.dig_t    = dig_t;
      status.dig_u    = dig_u;
      status.grp_last = grp_last;
      status.out_free = out_free;
   end

   always_comb begin
      for (int i = 0; i < DIG_N; i++) begin
         dig = bcd_ff[4*i +: 4];
         adj[4*i +: 4] = (dig >= DIG_FIVE) ? (dig + DIG_ADJ) : dig;
      end
   end

   always_comb begin
      tok      = TOK_ZERO;
      tok_last = 1'b0;
      case (cmd.kind)
         TK_SINGLE: begin
            tok      = over_ff ? TOK_RANGE : TOK_ZERO;
            tok_last = 1'b1;
         end
         TK_MINUS: begin
            tok = TOK_MINUS;
         end
         TK_HDIG: begin
            tok = {2'b00, dig_h};
         end
         TK_HWORD: begin
            tok      = TOK_HUNDRED;
            tok_last = grp_last && (dig_t == DIG_ZERO) && (dig_u == DIG_ZERO);
         end
         TK_TENS: begin
            if (dig_t == DIG_ONE) begin
               tok      = TOK_TEN + {2'b00, dig_u};
               tok_last = grp_last;
            end else begin
               tok      = TOK_TENS_OFS + {2'b00, dig_t};
               tok_last = grp_last && (dig_u == DIG_ZERO);
            end
         end
         TK_UNITS: begin
            tok      = {2'b00, dig_u};
            tok_last = grp_last;
         end
         TK_SCALE: begin
            tok      = TOK_HUNDRED + {{(WORD_W-GRP_W){1'b0}}, grp_ff};
            tok_last = low_zero;
         end
         default: begin
            tok = TOK_ZERO;
         end
      endcase
   end

   always_comb begin
      val_in   = cmd.load ? req_value : val_ff;
      neg_in   = neg_ff;
      over_in  = over_ff;
      bin_in   = bin_ff;
      bcd_in   = bcd_ff;
      grp_in   = grp_ff;
      word_in  = word_ff;
      last_in  = last_ff;
      valid_in = valid_ff && !rsp_ready;
      if (cmd.check) begin
         neg_in  = val_ff[VAL_W-1];
         over_in = status.over;
         bin_in  = mag[MAG_W-1:0];
         bcd_in  = '0;
         grp_in  = GRP_W'(GRP_N - 1);
      end
      if (cmd.conv) begin
         bcd_in = {adj[BCD_W-2:0], bin_ff[MAG_W-1]};
         bin_in = {bin_ff[MAG_W-2:0], 1'b0};
      end
      if (cmd.shift) begin
         bcd_in = {bcd_ff[BCD_W-13:0], 12'd0};
         grp_in = grp_ff - 1'b1;
      end
      if (cmd.emit) begin
         word_in  = tok;
         last_in  = tok_last;
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      val_ff  <= val_in;
      neg_ff  <= neg_in;
      over_ff <= over_in;
      bin_ff  <= bin_in;
      bcd_ff  <= bcd_in;
      grp_ff  <= grp_in;
      word_ff <= word_in;
      last_ff <= last_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_word  = word_ff;
   assign rsp_last  = last_ff;

`ifndef SYNTHESIS
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !valid_ff)
      else $error("Output register holds a token right after reset.");

   a_scale_group: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && (cmd.kind == TK_SCALE)) |-> !grp_last)
      else $error("Scale word emitted for the units group.");

   a_digit_range: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && (cmd.kind == TK_TENS)) |-> (dig_t <= 4'd9 && dig_u <= 4'd9))
      else $error("Converted group holds a digit above nine.");
`endif

endmodule
`default_nettype wire

// File: src/number_to_word_tokens.sv
// Top level of the number to English word-token speller.
`default_nettype none
// Each transaction takes one signed 64-bit value and returns its English spelling as
// one to 25 word tokens, the final one flagged by last. A value is taken only while the
// block is idle. It then goes through the range check. A zero or out-of-range value is
// answered with a single token. When the value is in range and nonzero, it runs the
// shift-and-add-3 BCD conversion, emits minus when negative, and then walks the six
// three-digit groups: it visits the token states of each group and then shifts to the
// next group. A token is emitted only once the output register is free, so a stalled
// result side holds the walk.
module number_to_word_tokens
   import nwt_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   nwt_req_if.sink    req_if,
   nwt_rsp_if.source  rsp_if
);

   cmd_type    cmd;
   status_type status;

   nwt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .status    (status),
      .cmd       (cmd)
   );

   nwt_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_value (req_if.value),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .rsp_word  (rsp_if.word),
      .rsp_last  (rsp_if.last)
   );

endmodule
`default_nettype wire

// File: verif/tb_top.sv
// Self-checking testbench for the number to English word-token speller.
module tb_top;
   import nwt_pkg::*;

   localparam logic [WORD_W-1:0] TOK_QUADRILLION = 6'd33;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int DRAIN_CYCLES = 200;
   localparam int MAX_REPORTS = 10;
   localparam int RANDOM_PER_PHASE = 45;

   typedef struct {
      logic [WORD_W-1:0] word;
      logic              last;
   } token_type;

   logic clock;
   logic reset;

   nwt_req_if req_ch ();
   nwt_rsp_if rsp_ch ();

   number_to_word_tokens DUT (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   logic [VAL_W-1:0] pending_values [$];
   token_type        expected_tokens [$];
   int               error_count = 0;
   int               cycle_count = 0;
   int               send_idle_pct = 0;
   int               recv_stall_pct = 0;

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.value = '0;
      rsp_ch.ready = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic void note_error(input string msg);
      if (error_count < MAX_REPORTS) begin
         $display("%s", msg);
      end
      error_count++;
   endfunction

   // Builds the token run for one value and appends it to the expected tokens.
   function automatic void spell_value(input logic [VAL_W-1:0] v);
      logic [VAL_W-1:0]  mag;
      logic [VAL_W-1:0]  divisor;
      logic [WORD_W-1:0] scale;
      logic [WORD_W-1:0] words [$];
      int unsigned       grp;
      int unsigned       hund;
      int unsigned       rest;
      token_type         entry;
      mag = v[VAL_W-1] ? (~v + 1'b1) : v;
      divisor = LIMIT;
      scale = TOK_QUADRILLION;
      if (mag > LIMIT) begin
         words.push_back(TOK_RANGE);
      end else if (mag == 0) begin
         words.push_back(TOK_ZERO);
      end else begin
         if (v[VAL_W-1]) begin
            words.push_back(TOK_MINUS);
         end
         while (divisor != 0) begin
            grp = int'(mag / divisor);
            if (grp != 0) begin
               hund = grp / 100;
               rest = grp % 100;
               if (hund != 0) begin
                  words.push_back(WORD_W'(hund));
                  words.push_back(TOK_HUNDRED);
               end
               if (rest >= 10 && rest <= 19) begin
                  words.push_back(WORD_W'(rest));
               end else begin
                  if (rest / 10 >= 2) begin
                     words.push_back(WORD_W'(rest / 10) + TOK_TENS_OFS);
                  end
                  if (rest % 10 != 0) begin
                     words.push_back(WORD_W'(rest % 10));
                  end
               end
               if (divisor > 1) begin
                  words.push_back(scale);
               end
            end
            mag = mag % divisor;
            divisor = divisor / 1000;
            scale = scale - 1'b1;
         end
      end
      foreach (words[i]) begin
         entry.word = words[i];
         entry.last = (i == words.size() - 1);
         expected_tokens.push_back(entry);
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || req_ch.ready) begin
         if (pending_values.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_ch.valid <= 1'b1;
            req_ch.value <= pending_values.pop_front();
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin : monitor
      token_type exp_tok;
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            spell_value(req_ch.value);
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_tokens.size() == 0) begin
               note_error($sformatf("unexpected token word=%0d last=%0d",
                                    rsp_ch.word, rsp_ch.last));
            end else begin
               exp_tok = expected_tokens.pop_front();
               if (rsp_ch.word !== exp_tok.word || rsp_ch.last !== exp_tok.last) begin
                  note_error($sformatf(
                     "mismatch: expected word=%0d last=%0d, got word=%0d last=%0d",
                     exp_tok.word, exp_tok.last, rsp_ch.word, rsp_ch.last));
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_top: errors");
         $finish;
      end
   end

   initial begin : stimulus
      logic [VAL_W-1:0] mag;
      int unsigned      grp;
      int unsigned      ngroups;
      int unsigned      sel;
      int               send_pct [4];
      int               recv_pct [4];
      send_pct = '{0, 83, 0, 8};
      recv_pct = '{0, 0, 83, 8};

      pending_values = '{
         64'd0, 64'd1, -64'd1, 64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF,
         LIMIT, -LIMIT, LIMIT + 1, -(LIMIT + 1), LIMIT - 1, -(LIMIT - 1),
         64'd7, 64'd10, 64'd15, 64'd19, 64'd20, 64'd21, 64'd90, 64'd99,
         64'd100, 64'd101, 64'd115, 64'd999, 64'd1000, 64'd1000001,
         64'd1000000000, 64'd12000019000700
      };

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      for (int phase = 0; phase < 4; phase++) begin
         send_idle_pct <= send_pct[phase];
         recv_stall_pct <= recv_pct[phase];
         for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
            sel = $urandom_range(99);
            if (sel < 8) begin
               mag = {$urandom, $urandom};
               pending_values.push_back(mag);
            end else if (sel < 12) begin
               mag = LIMIT - 1 + $urandom_range(2);
               pending_values.push_back($urandom_range(1) ? -mag : mag);
            end else begin
               mag = 0;
               ngroups = $urandom_range(1, 5);
               for (int k = 0; k < ngroups; k++) begin
                  case ($urandom_range(9))
                     0, 1: grp = 0;
                     2: grp = $urandom_range(10, 19);
                     3: grp = 10 * $urandom_range(2, 9);
                     4: grp = 100 * $urandom_range(1, 9);
                     default: grp = $urandom_range(999);
                  endcase
                  mag = mag * 1000 + grp;
               end
               pending_values.push_back($urandom_range(1) ? -mag : mag);
            end
         end
         while (pending_values.size() != 0 || req_ch.valid) @(posedge clock);
      end

      while (expected_tokens.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (expected_tokens.size() != 0) begin
         note_error($sformatf("%0d expected tokens never arrived", expected_tokens.size()));
      end
      if (error_count == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

endmodule

// File: sim.f
src/nwt_pkg.sv
src/nwt_req_if.sv
src/nwt_rsp_if.sv
src/nwt_ctrl.sv
src/nwt_dp.sv
src/number_to_word_tokens.sv
verif/tb_top.sv
